// ===== hdl/sdep_pkg.sv =====
// Shared types and constants for the serial decimal entry parser.
// Holds the character codes, parse phase and result burst descriptor.
// No dependencies.
`default_nettype none

package sdep_pkg;

	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_QMARK = 8'h3F;

	localparam int OUT_VALUE_BITS = 16;

	typedef enum logic [1:0] {
		PH_SKIP   = 2'd0,
		PH_DIGITS = 2'd1,
		PH_STOP   = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		BK_ECHO = 2'd0,
		BK_DONE = 2'd1,
		BK_BAD  = 2'd2
	} burst_kind_t;

	typedef struct packed {
		burst_kind_t                       kind;
		logic [7:0]                        echo;
		logic signed [OUT_VALUE_BITS-1:0]  value;
	} burst_t;

endpackage

`default_nettype wire

// ===== hdl/sdep_if.sv =====
// Valid/ready channel interfaces for the serial decimal entry parser.
// Depends on sdep_pkg for the value width.
`default_nettype none

interface sdep_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface sdep_tx_if;
	logic                                      valid;
	logic                                      ready;
	logic [7:0]                                tx_byte;
	logic                                      last;
	logic                                      entry_done;
	logic                                      bad_entry;
	logic signed [sdep_pkg::OUT_VALUE_BITS-1:0] value;

	modport source (output valid, output tx_byte, output last, output entry_done,
		output bad_entry, output value, input ready);
	modport sink (input valid, input tx_byte, input last, input entry_done,
		input bad_entry, input value, output ready);
endinterface

`default_nettype wire

// ===== hdl/sdep_emit.sv =====
// Result emitter: two-deep burst buffer; one tx request per cycle while tx.ready.
// Depends on sdep_pkg and sdep_tx_if.
`default_nettype none

module sdep_emit (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push_valid,
	output logic                  push_ready,
	input  wire sdep_pkg::burst_t push_burst,
	sdep_tx_if.source             tx
);

	sdep_pkg::burst_t head_q;
	sdep_pkg::burst_t tail_q;
	logic             head_vld_q;
	logic             tail_vld_q;
	logic [1:0]       idx_q;

	logic push;
	logic out_fire;
	logic pop;

	assign push_ready = !tail_vld_q;
	assign push       = push_valid && push_ready;
	assign out_fire   = tx.valid && tx.ready;
	assign pop        = out_fire && tx.last;

	always_comb begin
		tx.valid      = head_vld_q;
		tx.tx_byte    = head_q.echo;
		tx.last       = 1'b0;
		tx.entry_done = 1'b0;
		tx.bad_entry  = 1'b0;
		tx.value      = '0;
		case (idx_q)
			2'd0: begin
				tx.tx_byte = head_q.echo;
				tx.last    = (head_q.kind == sdep_pkg::BK_ECHO);
			end
			2'd1: begin
				tx.tx_byte = sdep_pkg::CH_LF;
			end
			2'd2: begin
				tx.tx_byte = sdep_pkg::CH_CR;
				if (head_q.kind == sdep_pkg::BK_DONE) begin
					tx.last       = 1'b1;
					tx.entry_done = 1'b1;
					tx.value      = head_q.value;
				end
			end
			default: begin
				tx.tx_byte    = sdep_pkg::CH_QMARK;
				tx.last       = 1'b1;
				tx.entry_done = 1'b1;
				tx.bad_entry  = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_vld_q <= 1'b0;
			tail_vld_q <= 1'b0;
			idx_q      <= 2'd0;
		end else begin
			if (out_fire) begin
				idx_q <= tx.last ? 2'd0 : 2'(idx_q + 2'd1);
			end
			if (pop) begin
				if (tail_vld_q) begin
					tail_vld_q <= 1'b0;
				end else if (!push) begin
					head_vld_q <= 1'b0;
				end
			end else if (push) begin
				if (!head_vld_q) begin
					head_vld_q <= 1'b1;
				end else begin
					tail_vld_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (tail_vld_q) begin
				head_q <= tail_q;
			end else if (push) begin
				head_q <= push_burst;
			end
		end else if (push) begin
			if (!head_vld_q) begin
				head_q <= push_burst;
			end else begin
				tail_q <= push_burst;
			end
		end
	end

	a_tail_needs_head: assert property (@(posedge clk) disable iff (!arst_n)
		tail_vld_q |-> head_vld_q)
		else $error("tail buffer holds a burst while head is empty");

	a_idx_only_multi: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q != 2'd0 |-> head_vld_q && head_q.kind != sdep_pkg::BK_ECHO)
		else $error("burst index advanced on an echo-only burst");

	a_idx3_bad: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q == 2'd3 |-> head_q.kind == sdep_pkg::BK_BAD)
		else $error("question mark slot reached on a non-rejected burst");

	a_value_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		tx.valid && tx.value != '0 |-> tx.entry_done && !tx.bad_entry)
		else $error("nonzero value outside a finished entry");

	a_stall_keeps_idx: assert property (@(posedge clk) disable iff (!arst_n)
		tx.valid && !tx.ready |=> $stable(idx_q))
		else $error("burst index moved while the output was stalled");

endmodule

`default_nettype wire

// ===== hdl/serial_decimal_entry_parser.sv =====
// Serial decimal entry parser top level: entry state, atoi-style parse, result bursts.
// Each accepted request is registered as a burst, sent on tx after any earlier bursts.
// Throughput: one request per cycle while the two-burst buffer has room; each request
// yields 1, 3 or 4 tx requests, one per cycle while tx is ready; tx sets the rate.
// Reset: asynchronous; clears the entry state and empties the result buffer.
// Depends on sdep_pkg, sdep_if and sdep_emit.
`default_nettype none

module serial_decimal_entry_parser #(
	parameter int MAX_UNSIGNED_CHARS = 5,
	parameter int MAX_SIGNED_CHARS   = 6,
	parameter int VALUE_BITS         = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	sdep_rx_if.sink   rx,
	sdep_tx_if.source tx
);

	localparam logic [2:0] MaxU = 3'(MAX_UNSIGNED_CHARS);
	localparam logic [2:0] MaxS = 3'(MAX_SIGNED_CHARS);

	logic [2:0]            count_q;
	logic                  first_sign_q;
	sdep_pkg::phase_t      phase_q;
	logic                  neg_q;
	logic [VALUE_BITS-1:0] acc_q;

	logic [2:0]            count_d;
	logic                  first_sign_d;
	sdep_pkg::phase_t      phase_d;
	logic                  neg_d;
	logic [VALUE_BITS-1:0] acc_d;

	logic [7:0]            c;
	logic                  is_digit;
	logic                  is_space;
	logic                  is_sign;
	logic                  too_long;
	logic [VALUE_BITS-1:0] mag;
	sdep_pkg::burst_t      burst;
	logic                  accept;

	assign c        = rx.rx_byte;
	assign accept   = rx.valid && rx.ready;
	assign is_digit = c inside {[8'h30:8'h39]};
	assign is_space = c inside {8'h20, [8'h09:8'h0D]};
	assign is_sign  = (c == sdep_pkg::CH_PLUS) || (c == sdep_pkg::CH_MINUS);
	assign too_long = ((count_q == MaxU) && !first_sign_q) || (count_q >= MaxS);
	assign mag      = neg_q ? VALUE_BITS'(-acc_q) : acc_q;

	always_comb begin
		count_d      = count_q;
		first_sign_d = first_sign_q;
		phase_d      = phase_q;
		neg_d        = neg_q;
		acc_d        = acc_q;
		burst.echo   = c;
		burst.kind   = sdep_pkg::BK_ECHO;
		burst.value  = '0;
		if (c == sdep_pkg::CH_CR) begin
			burst.kind   = sdep_pkg::BK_DONE;
			burst.value  = sdep_pkg::OUT_VALUE_BITS'(signed'(mag));
			count_d      = 3'd0;
			first_sign_d = 1'b0;
			phase_d      = sdep_pkg::PH_SKIP;
			neg_d        = 1'b0;
			acc_d        = '0;
		end else if (too_long) begin
			burst.kind   = sdep_pkg::BK_BAD;
			count_d      = 3'd0;
			first_sign_d = 1'b0;
			phase_d      = sdep_pkg::PH_SKIP;
			neg_d        = 1'b0;
			acc_d        = '0;
		end else begin
			if (count_q == 3'd0) begin
				first_sign_d = is_sign;
			end
			count_d = 3'(count_q + 3'd1);
			if (phase_q == sdep_pkg::PH_SKIP && is_space) begin
				phase_d = phase_q;
			end else if (phase_q == sdep_pkg::PH_SKIP && is_sign) begin
				neg_d   = (c == sdep_pkg::CH_MINUS);
				phase_d = sdep_pkg::PH_DIGITS;
			end else if (phase_q != sdep_pkg::PH_STOP && is_digit) begin
				acc_d   = VALUE_BITS'((acc_q << 3) + (acc_q << 1) + VALUE_BITS'(c[3:0]));
				phase_d = sdep_pkg::PH_DIGITS;
			end else begin
				phase_d = sdep_pkg::PH_STOP;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= 3'd0;
			first_sign_q <= 1'b0;
			phase_q      <= sdep_pkg::PH_SKIP;
			neg_q        <= 1'b0;
			acc_q        <= '0;
		end else if (accept) begin
			count_q      <= count_d;
			first_sign_q <= first_sign_d;
			phase_q      <= phase_d;
			neg_q        <= neg_d;
			acc_q        <= acc_d;
		end
	end

	sdep_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (rx.valid),
		.push_ready (rx.ready),
		.push_burst (burst),
		.tx         (tx)
	);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= MaxS)
		else $error("character count ran past the signed limit");

	a_neg_needs_sign: assert property (@(posedge clk) disable iff (!arst_n)
		neg_q |-> phase_q != sdep_pkg::PH_SKIP)
		else $error("negative flag set without a taken sign");

	a_cr_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && c == sdep_pkg::CH_CR |=> count_q == 3'd0 && acc_q == '0)
		else $error("entry state not cleared after carriage return");

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// Testbench for serial_decimal_entry_parser: directed entries, then random entries under
// several idle/stall mixes and a long receiver hold-off; a local atoi predictor checks each byte.
// Depends on sdep_pkg, sdep_if and the RTL of serial_decimal_entry_parser.
`timescale 1ns / 1ps

module tb_top;

	localparam int MAX_UNSIGNED_CHARS = 5;
	localparam int MAX_SIGNED_CHARS   = 6;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_FF     = 8'h0C;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DIGIT0 = 8'h30;
	localparam logic [7:0] CH_DIGIT9 = 8'h39;
	localparam logic [7:0] CH_TOP    = 8'hFF;

	typedef struct packed {
		logic [7:0]                                 tx_byte;
		logic                                       last;
		logic                                       entry_done;
		logic                                       bad_entry;
		logic signed [sdep_pkg::OUT_VALUE_BITS-1:0] value;
	} tx_beat_t;

	logic clk = 1'b0;
	logic arst_n;

	sdep_rx_if rx();
	sdep_tx_if tx();

	serial_decimal_entry_parser #(
		.MAX_UNSIGNED_CHARS(MAX_UNSIGNED_CHARS),
		.MAX_SIGNED_CHARS(MAX_SIGNED_CHARS),
		.VALUE_BITS(sdep_pkg::OUT_VALUE_BITS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.rx(rx),
		.tx(tx)
	);

	tx_beat_t tx_due[$];
	int mismatch_count = 0;
	int rx_sent = 0;
	int src_idle_pct = 0;
	int sink_stall_pct = 0;
	int hold_off_cycles = 0;

	logic [2:0]                          entry_len = '0;
	logic                                led_by_sign = 1'b0;
	sdep_pkg::phase_t                    scan_phase = sdep_pkg::PH_SKIP;
	logic                                minus_seen = 1'b0;
	logic [sdep_pkg::OUT_VALUE_BITS-1:0] digit_acc = '0;

	always #5 clk = ~clk;

	initial begin
		#2ms;
		$display("tb_top: FAIL");
		$finish;
	end

	task automatic flag_mismatch(input string what, input int got, input int want);
		if (mismatch_count < 40)
			$display("%0t tb_top: mismatch on %s: got %0d, want %0d", $time, what, got, want);
		mismatch_count++;
	endtask

	function automatic void clear_entry();
		entry_len = '0;
		led_by_sign = 1'b0;
		scan_phase = sdep_pkg::PH_SKIP;
		minus_seen = 1'b0;
		digit_acc = '0;
	endfunction

	function automatic void queue_beat(input logic [7:0] b, input logic lst, input logic done,
			input logic bad, input logic [sdep_pkg::OUT_VALUE_BITS-1:0] v);
		tx_beat_t beat;
		beat.tx_byte = b;
		beat.last = lst;
		beat.entry_done = done;
		beat.bad_entry = bad;
		beat.value = v;
		tx_due.push_back(beat);
	endfunction

	function automatic void predict_rx_byte(input logic [7:0] c);
		logic digit, blank, sign;
		logic [sdep_pkg::OUT_VALUE_BITS-1:0] v;
		digit = (c >= CH_DIGIT0) && (c <= CH_DIGIT9);
		blank = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= sdep_pkg::CH_CR));
		sign = (c == sdep_pkg::CH_PLUS) || (c == sdep_pkg::CH_MINUS);
		if (c == sdep_pkg::CH_CR) begin
			v = minus_seen ? -digit_acc : digit_acc;
			queue_beat(c, 1'b0, 1'b0, 1'b0, '0);
			queue_beat(sdep_pkg::CH_LF, 1'b0, 1'b0, 1'b0, '0);
			queue_beat(sdep_pkg::CH_CR, 1'b1, 1'b1, 1'b0, v);
			clear_entry();
		end else if ((entry_len == MAX_UNSIGNED_CHARS && !led_by_sign) ||
				entry_len >= MAX_SIGNED_CHARS) begin
			queue_beat(c, 1'b0, 1'b0, 1'b0, '0);
			queue_beat(sdep_pkg::CH_LF, 1'b0, 1'b0, 1'b0, '0);
			queue_beat(sdep_pkg::CH_CR, 1'b0, 1'b0, 1'b0, '0);
			queue_beat(sdep_pkg::CH_QMARK, 1'b1, 1'b1, 1'b1, '0);
			clear_entry();
		end else begin
			if (entry_len == 0)
				led_by_sign = sign;
			if (scan_phase == sdep_pkg::PH_SKIP && blank) begin
			end else if (scan_phase == sdep_pkg::PH_SKIP && sign) begin
				minus_seen = (c == sdep_pkg::CH_MINUS);
				scan_phase = sdep_pkg::PH_DIGITS;
			end else if (scan_phase != sdep_pkg::PH_STOP && digit) begin
				digit_acc = sdep_pkg::OUT_VALUE_BITS'(digit_acc * 10 + (c - CH_DIGIT0));
				scan_phase = sdep_pkg::PH_DIGITS;
			end else begin
				scan_phase = sdep_pkg::PH_STOP;
			end
			entry_len = entry_len + 3'd1;
			queue_beat(c, 1'b1, 1'b0, 1'b0, '0);
		end
	endfunction

	// check the oldest expected byte first, then predict from any request taken this edge
	always @(posedge clk) begin : check_and_predict
		tx_beat_t want;
		if (arst_n && tx.valid && tx.ready) begin
			if (tx_due.size() == 0) begin
				flag_mismatch("tx request with none expected", int'(tx.tx_byte), -1);
			end else begin
				want = tx_due.pop_front();
				if (tx.tx_byte !== want.tx_byte)
					flag_mismatch("tx_byte", int'(tx.tx_byte), int'(want.tx_byte));
				if (tx.last !== want.last)
					flag_mismatch("last", int'(tx.last), int'(want.last));
				if (tx.entry_done !== want.entry_done)
					flag_mismatch("entry_done", int'(tx.entry_done), int'(want.entry_done));
				if (tx.bad_entry !== want.bad_entry)
					flag_mismatch("bad_entry", int'(tx.bad_entry), int'(want.bad_entry));
				if (tx.value !== want.value)
					flag_mismatch("value", int'(tx.value), int'(want.value));
			end
		end
		if (arst_n && rx.valid && rx.ready)
			predict_rx_byte(rx.rx_byte);
	end

	initial begin
		tx.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_cycles > 0) begin
				tx.ready = 1'b0;
				hold_off_cycles--;
			end else begin
				tx.ready = ($urandom_range(99) >= sink_stall_pct);
			end
		end
	end

	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < src_idle_pct) begin
			@(negedge clk);
			rx.valid = 1'b0;
			rx.rx_byte = 8'($urandom_range(255));
			@(posedge clk);
		end
		@(negedge clk);
		rx.valid = 1'b1;
		rx.rx_byte = b;
		do
			@(posedge clk);
		while (!rx.ready);
		rx_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	task automatic send_random_entry();
		logic [7:0] seq[$];
		logic [7:0] b;
		int kind, limit;
		kind = $urandom_range(99);
		if ($urandom_range(3) == 0)
			seq.push_back($urandom_range(1) ? CH_SPACE : 8'($urandom_range(CH_TAB, CH_FF)));
		if ($urandom_range(1))
			seq.push_back($urandom_range(1) ? sdep_pkg::CH_MINUS : sdep_pkg::CH_PLUS);
		limit = (seq.size() > 0 &&
			(seq[0] == sdep_pkg::CH_PLUS || seq[0] == sdep_pkg::CH_MINUS)) ?
			MAX_SIGNED_CHARS : MAX_UNSIGNED_CHARS;
		if (kind < 60) begin
			repeat ($urandom_range(limit - seq.size()))
				seq.push_back(8'(CH_DIGIT0 + $urandom_range(9)));
			seq.push_back(sdep_pkg::CH_CR);
		end else if (kind < 75) begin
			while (seq.size() <= limit)
				seq.push_back(8'(CH_DIGIT0 + $urandom_range(9)));
		end else if (kind < 90) begin
			repeat ($urandom_range(limit - seq.size()))
				seq.push_back(8'(CH_DIGIT0 + $urandom_range(9)));
			while (seq.size() < limit) begin
				b = 8'($urandom_range(255));
				if (b != sdep_pkg::CH_CR)
					seq.push_back(b);
			end
			seq.push_back(sdep_pkg::CH_CR);
		end else begin
			seq.delete();
			repeat ($urandom_range(1, 8))
				seq.push_back(8'($urandom_range(255)));
			if ($urandom_range(1))
				seq.push_back(sdep_pkg::CH_CR);
		end
		foreach (seq[i])
			send_byte(seq[i]);
	endtask

	task automatic test_directed_extremes();
		send_byte(sdep_pkg::CH_CR);
		send_text("-32768");
		send_byte(sdep_pkg::CH_CR);
		send_text("99999");
		send_byte(sdep_pkg::CH_CR);
	endtask

	task automatic test_directed_overlong();
		send_byte(sdep_pkg::CH_LF);
		send_text(" 12x5");
		send_byte(sdep_pkg::CH_PLUS);
		send_text("9a");
		send_byte(CH_NUL);
		send_byte(CH_TOP);
		send_text(" 1");
	endtask

	task automatic test_random_entries(input int n_items, input int src_pct, input int sink_pct);
		int stop_at;
		stop_at = rx_sent + n_items;
		src_idle_pct = src_pct;
		sink_stall_pct = sink_pct;
		while (rx_sent < stop_at)
			send_random_entry();
	endtask

	task automatic test_receiver_hold_off();
		int stop_at;
		src_idle_pct = 0;
		sink_stall_pct = 0;
		hold_off_cycles = 300;
		stop_at = rx_sent + 40;
		while (rx_sent < stop_at)
			send_random_entry();
	endtask

	initial begin
		arst_n = 1'b0;
		rx.valid = 1'b0;
		rx.rx_byte = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_extremes();
		test_directed_overlong();
		test_random_entries(80, 0, 0);
		test_random_entries(80, 62, 0);
		test_random_entries(80, 0, 62);
		test_random_entries(80, 7, 7);
		test_receiver_hold_off();

		@(negedge clk);
		rx.valid = 1'b0;
		sink_stall_pct = 0;
		while (tx_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/sdep_pkg.sv
hdl/sdep_if.sv
hdl/sdep_emit.sv
hdl/serial_decimal_entry_parser.sv
sim/tb_top.sv
